/* rtl/npa_pkg.sv */
// ----------------------------------------------------------------------------
// npa_pkg
// Shared types and constants of the nibble packet phase aligner.
// ----------------------------------------------------------------------------
`default_nettype none
package npa_pkg;

    localparam int DEF_BUFFER_BYTES         = 4090;
    localparam int DEF_RING_DEPTH           = 4096;
    localparam int DEF_SCORE_WINDOW_BYTES   = 800;
    localparam int DEF_MAX_WORDS_PER_BUFFER = 1024;

    localparam int          PHASE_COUNT    = 10;
    localparam int          WORD_NIBBLES   = 8;
    localparam int          TAIL_MAX       = 9;
    localparam logic [15:0] HEARTBEAT_ADDR = 16'hC0FF;
    localparam int          PADDR_W        = 4;
    localparam int          OUT_TDATA_W    = 112;

    localparam logic [15:0] RESET_WINDOW_LOW  = 16'd49152;
    localparam logic [15:0] RESET_WINDOW_HIGH = 16'd49407;

    typedef enum logic [1:0] {
        REG_LENGTH_EOF_MODE = 2'd0,
        REG_WINDOW_LOW      = 2'd1,
        REG_WINDOW_HIGH     = 2'd2
    } npa_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SCORE_START,
        ST_SCORE,
        ST_PICK,
        ST_STITCH,
        ST_WALK,
        ST_FINISH
    } npa_state_t;

    typedef struct packed {
        logic capture;
        logic pop;
        logic eob_clear;
        logic stream_start;
        logic walk_mode;
        logic stream_en;
        logic pick_step;
        logic stitch;
        logic finish;
        logic load_simple;
        logic load_pop;
    } npa_cmd_t;

    typedef struct packed {
        logic stream_done;
        logic pick_last;
        logic out_free;
    } npa_status_t;

endpackage
`default_nettype wire

/* rtl/npa_dp.sv */
// ----------------------------------------------------------------------------
// npa_dp
// Datapath: capture memory, nibble stream, phase scores, word ring,
// counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module npa_dp #(
    parameter int BUFFER_BYTES         = npa_pkg::DEF_BUFFER_BYTES,
    parameter int RING_DEPTH           = npa_pkg::DEF_RING_DEPTH,
    parameter int SCORE_WINDOW_BYTES   = npa_pkg::DEF_SCORE_WINDOW_BYTES,
    parameter int MAX_WORDS_PER_BUFFER = npa_pkg::DEF_MAX_WORDS_PER_BUFFER
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  npa_pkg::npa_cmd_t                  cmd,
    output npa_pkg::npa_status_t               status,
    input  wire [3:0]                          nibble,
    input  wire                                length_eof_mode,
    input  wire [15:0]                         window_low,
    input  wire [15:0]                         window_high,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // popped_word, phase_offset, words_pushed, seen_count, drop_count
    output logic [npa_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // popped_valid
    output logic [0:0]                         m_tuser
);
    import npa_pkg::*;

    localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);
    localparam int IDX_W  = $clog2(BUFFER_BYTES);
    localparam int SC_W   = $clog2(SCORE_WINDOW_BYTES / PHASE_COUNT + 2);
    localparam int RING_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(MAX_WORDS_PER_BUFFER + 1);

    logic [3:0]        cap_mem [BUFFER_BYTES];
    logic [3:0]        cap_rdata_reg;
    logic [LEN_W-1:0]  cap_len_reg;
    logic [3:0]        head_reg [WORD_NIBBLES];
    logic [3:0]        tail_sh_reg [TAIL_MAX];
    logic [3:0]        tail_reg [TAIL_MAX];
    logic [3:0]        tail_len_reg;

    logic [LEN_W-1:0]  rd_ptr_reg;
    logic [LEN_W-1:0]  rpos_reg;
    logic              rvalid_reg;
    logic              walk_mode_reg;
    logic [3:0]        smod_reg;
    logic [3:0]        sh_reg [WORD_NIBBLES];
    logic [LEN_W-1:0]  limit;
    logic              rd_en;
    logic [31:0]       stream_word;
    logic              word_ok;

    logic [SC_W-1:0]   score_reg [PHASE_COUNT];
    logic [3:0]        pick_idx_reg;
    logic [3:0]        best_reg;
    logic [SC_W-1:0]   top_score_reg;
    logic              pick_take;
    logic [4:0]        phase_reg;

    logic [31:0]       ring_mem [RING_DEPTH];
    logic [31:0]       ring_rdata_reg;
    logic              pop_hit_reg;
    logic [RING_W-1:0] wr_idx_reg;
    logic [RING_W-1:0] rd_idx_reg;
    logic [RING_W-1:0] wr_nxt;
    logic [RING_W-1:0] rd_nxt;
    logic              ring_full;
    logic              walk_on_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [31:0]       seen_reg;
    logic [31:0]       drop_reg;

    logic [3:0]        tb;
    logic [3:0]        hb;
    logic [31:0]       stitch_word;
    logic              stitch_ok;
    logic              push_en;
    logic [31:0]       push_word;

    logic              out_valid_reg;
    logic [31:0]       out_word_reg;
    logic              out_flag_reg;
    logic [4:0]        out_phase_reg;
    logic [10:0]       out_pushed_reg;
    logic [31:0]       out_seen_reg;
    logic [31:0]       out_drop_reg;

    always_comb begin
        if (walk_mode_reg || 32'(cap_len_reg) < SCORE_WINDOW_BYTES) begin
            limit = cap_len_reg;
        end else begin
            limit = LEN_W'(SCORE_WINDOW_BYTES);
        end
        rd_en = cmd.stream_en && (rd_ptr_reg < limit);
        for (int k = 0; k < WORD_NIBBLES - 1; k++) begin
            stream_word[4*k +: 4] = sh_reg[k+1];
        end
        stream_word[31:28] = cap_rdata_reg;
        word_ok = rvalid_reg && (rpos_reg >= LEN_W'(WORD_NIBBLES - 1));
    end

    assign status.stream_done = !rd_en && !rvalid_reg;
    assign status.pick_last   = (pick_idx_reg == 4'(PHASE_COUNT - 1));
    assign status.out_free    = !out_valid_reg || m_tready;

    assign pick_take = (pick_idx_reg == 4'd0) || (score_reg[pick_idx_reg] > top_score_reg);

    always_comb begin
        tb = (phase_reg[3:0] == 4'd1) ? 4'd8 : 4'(PHASE_COUNT) - phase_reg[3:0];
        hb = 4'd8 - tb;
        for (int i = 0; i < WORD_NIBBLES; i++) begin
            if (4'(i) < tb) begin
                stitch_word[4*i +: 4] = tail_reg[4'(TAIL_MAX) - tb + 4'(i)];
            end else begin
                stitch_word[4*i +: 4] = head_reg[3'(4'(i) - tb)];
            end
        end
        stitch_ok = length_eof_mode && (phase_reg != 5'd0) && (tail_len_reg != 4'd0)
                    && (tail_len_reg >= tb) && (cap_len_reg >= LEN_W'(hb));
    end

    always_comb begin
        push_en   = 1'b0;
        push_word = stream_word;
        if (cmd.stitch) begin
            push_en   = stitch_ok;
            push_word = stitch_word;
        end else if (walk_mode_reg && word_ok && walk_on_reg
                     && (smod_reg == phase_reg[3:0])
                     && (count_reg < CNT_W'(MAX_WORDS_PER_BUFFER))) begin
            push_en = 1'b1;
        end
    end

    assign wr_nxt    = (wr_idx_reg == RING_W'(RING_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    assign rd_nxt    = (rd_idx_reg == RING_W'(RING_DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
    assign ring_full = (wr_nxt == rd_idx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture && cap_len_reg < LEN_W'(BUFFER_BYTES)) begin
            cap_mem[cap_len_reg[IDX_W-1:0]] <= nibble;
        end
        if (rd_en) begin
            cap_rdata_reg <= cap_mem[rd_ptr_reg[IDX_W-1:0]];
        end
        if (push_en && !ring_full) begin
            ring_mem[wr_idx_reg] <= push_word;
        end
        if (cmd.pop) begin
            ring_rdata_reg <= ring_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_len_reg    <= '0;
            tail_len_reg   <= '0;
            rd_ptr_reg     <= '0;
            rvalid_reg     <= 1'b0;
            walk_mode_reg  <= 1'b0;
            smod_reg       <= '0;
            pick_idx_reg   <= '0;
            best_reg       <= '0;
            top_score_reg  <= '0;
            phase_reg      <= 5'h1F;
            pop_hit_reg    <= 1'b0;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            walk_on_reg    <= 1'b0;
            count_reg      <= '0;
            seen_reg       <= '0;
            drop_reg       <= '0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < PHASE_COUNT; k++) begin
                score_reg[k] <= '0;
            end
        end else begin
            if (cmd.capture && cap_len_reg < LEN_W'(BUFFER_BYTES)) begin
                cap_len_reg <= cap_len_reg + 1'b1;
                if (cap_len_reg < LEN_W'(WORD_NIBBLES)) begin
                    head_reg[cap_len_reg[2:0]] <= nibble;
                end
                for (int k = 0; k < TAIL_MAX - 1; k++) begin
                    tail_sh_reg[k] <= tail_sh_reg[k+1];
                end
                tail_sh_reg[TAIL_MAX-1] <= nibble;
            end

            if (cmd.eob_clear) begin
                count_reg <= '0;
                for (int k = 0; k < PHASE_COUNT; k++) begin
                    score_reg[k] <= '0;
                end
            end

            if (cmd.stream_start) begin
                rd_ptr_reg    <= '0;
                rvalid_reg    <= 1'b0;
                smod_reg      <= 4'd3;
                walk_mode_reg <= cmd.walk_mode;
                walk_on_reg   <= 1'b1;
                pick_idx_reg  <= '0;
            end else begin
                rvalid_reg <= rd_en;
                if (rd_en) begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                    rpos_reg   <= rd_ptr_reg;
                end
                if (rvalid_reg) begin
                    for (int k = 0; k < WORD_NIBBLES - 1; k++) begin
                        sh_reg[k] <= sh_reg[k+1];
                    end
                    sh_reg[WORD_NIBBLES-1] <= cap_rdata_reg;
                    smod_reg <= (smod_reg == 4'(PHASE_COUNT - 1)) ? 4'd0 : smod_reg + 1'b1;
                    if (!walk_mode_reg && word_ok && stream_word[31:16] >= window_low
                        && stream_word[31:16] <= window_high) begin
                        for (int k = 0; k < PHASE_COUNT; k++) begin
                            if (smod_reg == 4'(k)) begin
                                score_reg[k] <= score_reg[k] + 1'b1;
                            end
                        end
                    end
                end
            end

            if (cmd.pick_step) begin
                pick_idx_reg <= pick_idx_reg + 1'b1;
                if (pick_take) begin
                    best_reg      <= pick_idx_reg;
                    top_score_reg <= score_reg[pick_idx_reg];
                end
                if (pick_idx_reg == 4'(PHASE_COUNT - 1)) begin
                    phase_reg <= {1'b0, pick_take ? pick_idx_reg : best_reg};
                end
            end

            if (push_en) begin
                if (ring_full) begin
                    drop_reg <= drop_reg + 1'b1;
                    if (!cmd.stitch) begin
                        walk_on_reg <= 1'b0;
                    end
                end else begin
                    wr_idx_reg <= wr_nxt;
                    count_reg  <= count_reg + 1'b1;
                    if (push_word[31:16] != HEARTBEAT_ADDR) begin
                        seen_reg <= seen_reg + 1'b1;
                    end
                end
            end

            if (cmd.pop) begin
                pop_hit_reg <= (rd_idx_reg != wr_idx_reg);
                if (rd_idx_reg != wr_idx_reg) begin
                    rd_idx_reg <= rd_nxt;
                end
            end

            if (cmd.finish) begin
                cap_len_reg <= '0;
                if (length_eof_mode) begin
                    tail_len_reg <= (cap_len_reg < LEN_W'(TAIL_MAX)) ? 4'(cap_len_reg)
                                                                     : 4'(TAIL_MAX);
                    for (int k = 0; k < TAIL_MAX; k++) begin
                        tail_reg[k] <= tail_sh_reg[k];
                    end
                end else begin
                    tail_len_reg <= '0;
                end
            end

            if (cmd.load_simple || cmd.load_pop || cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_simple || cmd.load_pop || cmd.finish) begin
            out_word_reg   <= (cmd.load_pop && pop_hit_reg) ? ring_rdata_reg : 32'd0;
            out_flag_reg   <= cmd.load_pop && pop_hit_reg;
            out_phase_reg  <= phase_reg;
            out_pushed_reg <= cmd.finish ? 11'(count_reg) : 11'd0;
            out_seen_reg   <= seen_reg;
            out_drop_reg   <= drop_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_drop_reg, out_seen_reg, out_pushed_reg, out_phase_reg, out_word_reg};
    assign m_tuser  = out_flag_reg;

endmodule
`default_nettype wire

/* rtl/npa_ctrl.sv */
// ----------------------------------------------------------------------------
// npa_ctrl
// Controller: accepts items and sequences scoring, phase pick, stitch,
// walk and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module npa_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire                  s_op,
    input  wire                  s_tlast,
    input  npa_pkg::npa_status_t status,
    output npa_pkg::npa_cmd_t    cmd
);
    import npa_pkg::*;

    npa_state_t state_reg;
    npa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = status.out_free;
                if (s_tvalid && status.out_free) begin
                    if (s_op) begin
                        cmd.pop    = 1'b1;
                        state_next = ST_POP;
                    end else begin
                        cmd.capture = 1'b1;
                        if (s_tlast) begin
                            cmd.eob_clear = 1'b1;
                            state_next    = ST_SCORE_START;
                        end else begin
                            cmd.load_simple = 1'b1;
                        end
                    end
                end
            end
            ST_POP: begin
                cmd.load_pop = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SCORE_START: begin
                cmd.stream_start = 1'b1;
                state_next       = ST_SCORE;
            end
            ST_SCORE: begin
                cmd.stream_en = 1'b1;
                if (status.stream_done) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                cmd.pick_step = 1'b1;
                if (status.pick_last) begin
                    state_next = ST_STITCH;
                end
            end
            ST_STITCH: begin
                cmd.stitch       = 1'b1;
                cmd.stream_start = 1'b1;
                cmd.walk_mode    = 1'b1;
                state_next       = ST_WALK;
            end
            ST_WALK: begin
                cmd.stream_en = 1'b1;
                if (status.stream_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/nibble_packet_phase_aligner.sv */
// ----------------------------------------------------------------------------
// nibble_packet_phase_aligner
// Capture: one transfer per cycle while the output is free; a non-last capture
// result is valid in the next cycle. A pop's ring read becomes its result in
// ST_POP, which takes no transfer. End of buffer: scoring reads min(len,
// SCORE_WINDOW_BYTES) nibbles and emission len, one per cycle via the single
// capture memory read port, around a 10-step phase pick; the result waits for
// a free output. Reset (aresetn low, synchronous) clears control and counters.
// ----------------------------------------------------------------------------
`default_nettype none
module nibble_packet_phase_aligner #(
    parameter int BUFFER_BYTES         = npa_pkg::DEF_BUFFER_BYTES,
    parameter int RING_DEPTH           = npa_pkg::DEF_RING_DEPTH,
    parameter int SCORE_WINDOW_BYTES   = npa_pkg::DEF_SCORE_WINDOW_BYTES,
    parameter int MAX_WORDS_PER_BUFFER = npa_pkg::DEF_MAX_WORDS_PER_BUFFER
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // data_byte
    input  wire [7:0]                       s_tdata,
    // operation
    input  wire [0:0]                       s_tuser,
    input  wire                             s_tlast,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // popped_word, phase_offset, words_pushed, seen_count, drop_count
    output logic [npa_pkg::OUT_TDATA_W-1:0] m_tdata,
    // popped_valid
    output logic [0:0]                      m_tuser,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [npa_pkg::PADDR_W-1:0]      paddr,
    input  wire [31:0]                      pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import npa_pkg::*;

    logic        mode_reg;
    logic [15:0] win_lo_reg;
    logic [15:0] win_hi_reg;
    npa_cmd_t    cmd;
    npa_status_t status;
    npa_reg_t    reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = npa_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            win_lo_reg <= RESET_WINDOW_LOW;
            win_hi_reg <= RESET_WINDOW_HIGH;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_LENGTH_EOF_MODE: mode_reg   <= pwdata[0];
                REG_WINDOW_LOW:      win_lo_reg <= pwdata[15:0];
                REG_WINDOW_HIGH:     win_hi_reg <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_LENGTH_EOF_MODE: prdata = {31'd0, mode_reg};
            REG_WINDOW_LOW:      prdata = {16'd0, win_lo_reg};
            REG_WINDOW_HIGH:     prdata = {16'd0, win_hi_reg};
            default:             prdata = 32'd0;
        endcase
    end

    npa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[0]),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    npa_dp #(
        .BUFFER_BYTES         (BUFFER_BYTES),
        .RING_DEPTH           (RING_DEPTH),
        .SCORE_WINDOW_BYTES   (SCORE_WINDOW_BYTES),
        .MAX_WORDS_PER_BUFFER (MAX_WORDS_PER_BUFFER)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .nibble          (s_tdata[3:0]),
        .length_eof_mode (mode_reg),
        .window_low      (win_lo_reg),
        .window_high     (win_hi_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

endmodule
`default_nettype wire

/* bench/nibble_packet_phase_aligner_tb.sv */
// ----------------------------------------------------------------------------
// nibble_packet_phase_aligner_tb
// Self-checking bench: streams capture and pop transfers into the aligner,
// predicts every result from its own copy of the buffer, tail and word ring,
// and compares each output transfer field by field. Covers packet phases,
// tail stitching, window extremes and a buffer longer than the scoring span.
// ----------------------------------------------------------------------------
`default_nettype none
module nibble_packet_phase_aligner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import npa_pkg::*;

    localparam int BUF_BYTES  = DEF_BUFFER_BYTES;
    localparam int RING_SLOTS = DEF_RING_DEPTH;
    localparam int SCORE_SPAN = DEF_SCORE_WINDOW_BYTES;
    localparam int MAX_WORDS  = DEF_MAX_WORDS_PER_BUFFER;
    localparam int IDLE_LIMIT = 60000;

    typedef struct {
        bit       pop;
        bit [7:0] data;
        bit       eob;
    } nib_xfer_t;

    typedef struct {
        logic [31:0] word;
        logic        valid;
        logic [4:0]  phase;
        logic [10:0] pushed;
        logic [31:0] seen;
        logic [31:0] drops;
    } aligner_out_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic [0:0]             s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    nibble_packet_phase_aligner dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    nib_xfer_t    xfer_q[$];
    aligner_out_t expected_q[$];
    int           errors;
    int           idle_cycles;
    bit           hold_send;
    bit           apb_fire;

    // aligner shadow state
    logic [3:0]  cap_mem[BUF_BYTES];
    int          cap_len;
    logic [3:0]  tail_mem[TAIL_MAX];
    int          tail_len;
    logic [4:0]  cur_phase;
    logic [31:0] ring_mem[RING_SLOTS];
    int          wr_idx;
    int          rd_idx;
    logic [31:0] drop_cnt;
    logic [31:0] seen_cnt;
    bit          eof_mode;
    logic [15:0] win_lo;
    logic [15:0] win_hi;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] pack_at(int base);
        logic [31:0] w;
        w = '0;
        for (int i = 0; i < WORD_NIBBLES; i++) w[4*i +: 4] = cap_mem[base + i];
        return w;
    endfunction

    function automatic bit ring_push(logic [31:0] w);
        int n;
        n = (wr_idx + 1) % RING_SLOTS;
        if (n == rd_idx) begin
            drop_cnt++;
            return 1'b0;
        end
        ring_mem[wr_idx] = w;
        wr_idx = n;
        if (w[31:16] != HEARTBEAT_ADDR) seen_cnt++;
        return 1'b1;
    endfunction

    function automatic int close_buffer();
        int          len, span, best, top_score, score, cnt, tb, hb, pos;
        logic [31:0] w;
        len = cap_len;
        span = (len < SCORE_SPAN) ? len : SCORE_SPAN;
        best = 0;
        top_score = -1;
        cnt = 0;
        for (int off = 0; off < PHASE_COUNT; off++) begin
            score = 0;
            for (int p = off; p + 7 < span; p += PHASE_COUNT) begin
                w = pack_at(p);
                if (w[31:16] >= win_lo && w[31:16] <= win_hi) score++;
            end
            if (score > top_score) begin
                top_score = score;
                best = off;
            end
        end
        cur_phase = best[4:0];
        if (eof_mode && best != 0 && tail_len > 0) begin
            tb = (PHASE_COUNT - best < 8) ? PHASE_COUNT - best : 8;
            hb = 8 - tb;
            if (tail_len >= tb && len >= hb) begin
                w = '0;
                for (int i = 0; i < tb; i++) w[4*i +: 4] = tail_mem[tail_len - tb + i];
                for (int i = 0; i < hb; i++) w[4*(tb+i) +: 4] = cap_mem[i];
                if (ring_push(w)) cnt++;
            end
        end
        pos = best;
        while (pos + 8 <= len && cnt < MAX_WORDS) begin
            if (!ring_push(pack_at(pos))) break;
            cnt++;
            pos += PHASE_COUNT;
        end
        if (eof_mode) begin
            tail_len = (len < TAIL_MAX) ? len : TAIL_MAX;
            for (int i = 0; i < tail_len; i++) tail_mem[i] = cap_mem[len - tail_len + i];
        end else begin
            tail_len = 0;
        end
        cap_len = 0;
        return cnt;
    endfunction

    function automatic aligner_out_t aligner_step(nib_xfer_t x);
        aligner_out_t r;
        r.word = '0;
        r.valid = 1'b0;
        r.pushed = '0;
        if (x.pop) begin
            if (rd_idx != wr_idx) begin
                r.word = ring_mem[rd_idx];
                r.valid = 1'b1;
                rd_idx = (rd_idx + 1) % RING_SLOTS;
            end
        end else begin
            if (cap_len < BUF_BYTES) begin
                cap_mem[cap_len] = x.data[3:0];
                cap_len++;
            end
            if (x.eob) r.pushed = 11'(close_buffer());
        end
        r.phase = cur_phase;
        r.seen = seen_cnt;
        r.drops = drop_cnt;
        return r;
    endfunction

    // stimulus builders
    task automatic add_pops(int n);
        nib_xfer_t x;
        for (int i = 0; i < n; i++) begin
            x.pop = 1'b1;
            x.data = 8'($urandom);
            x.eob = 1'($urandom);
            xfer_q.push_back(x);
        end
    endtask

    task automatic add_buffer(int len, int ph, int good_pct);
        nib_xfer_t   x;
        logic [31:0] w;
        int          rel, span;
        w = $urandom;
        for (int p = 0; p < len; p++) begin
            rel = (p + PHASE_COUNT - (ph % PHASE_COUNT)) % PHASE_COUNT;
            if (rel == 0) begin
                w = $urandom;
                if ($urandom_range(99) < good_pct) begin
                    if (win_lo <= win_hi) begin
                        span = int'(win_hi) - int'(win_lo);
                        w[31:16] = 16'(int'(win_lo) + $urandom_range(span));
                    end
                end
                if ($urandom_range(9) == 0) w[31:16] = HEARTBEAT_ADDR;
            end
            x.pop = 1'b0;
            x.data = 8'($urandom);
            if (rel < WORD_NIBBLES) x.data[3:0] = w[4*rel +: 4];
            x.eob = (p == len - 1);
            xfer_q.push_back(x);
        end
    endtask

    task automatic wait_drained();
        while (xfer_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(posedge aclk);
        repeat (BUF_BYTES + SCORE_SPAN + 64) @(posedge aclk);
    endtask

    task automatic apb_write(npa_reg_t r, logic [31:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({r, 2'b00});
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (r)
            REG_LENGTH_EOF_MODE: eof_mode = v[0];
            REG_WINDOW_LOW:      win_lo = v[15:0];
            REG_WINDOW_HIGH:     win_hi = v[15:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(bit m, logic [15:0] lo, logic [15:0] hi);
        wait_drained();
        apb_write(REG_LENGTH_EOF_MODE, {31'd0, m});
        apb_write(REG_WINDOW_LOW, {16'd0, lo});
        apb_write(REG_WINDOW_HIGH, {16'd0, hi});
    endtask

    // sender
    int burst_left;
    int gap_left;

    always @(posedge aclk) begin
        nib_xfer_t    x;
        aligner_out_t e;
        bit           fire;
        fire = s_tvalid && s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left <= 1;
            gap_left <= 0;
        end else begin
            if (fire) begin
                x.pop = s_tuser[0];
                x.data = s_tdata;
                x.eob = s_tlast;
                e = aligner_step(x);
                expected_q.push_back(e);
            end
            if (!s_tvalid || fire) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (xfer_q.size() != 0 && !hold_send) begin
                    x = xfer_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= x.pop;
                    s_tdata <= x.data;
                    s_tlast <= x.eob;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    int stall_phase;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 700) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom);
                2: m_tready <= ($urandom_range(3) == 0);
                default: m_tready <= ((stall_phase % 9) > 2);
            endcase
        end
    end

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h, got %h", name, e, a);
        end
    endtask

    always @(posedge aclk) begin
        aligner_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output transfer %h", m_tdata);
            end else begin
                e = expected_q.pop_front();
                check_field("popped_word", e.word, m_tdata[31:0]);
                check_field("popped_valid", 32'(e.valid), 32'(m_tuser[0]));
                check_field("phase_offset", 32'(e.phase), 32'(m_tdata[36:32]));
                check_field("words_pushed", 32'(e.pushed), 32'(m_tdata[47:37]));
                check_field("seen_count", e.seen, m_tdata[79:48]);
                check_field("drop_count", e.drops, m_tdata[111:80]);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        apb_fire = psel && penable;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || apb_fire) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        errors = 0;
        idle_cycles = 0;
        hold_send = 1'b0;
        cap_len = 0;
        tail_len = 0;
        cur_phase = 5'h1F;
        wr_idx = 0;
        rd_idx = 0;
        drop_cnt = '0;
        seen_cnt = '0;
        eof_mode = 1'b0;
        win_lo = RESET_WINDOW_LOW;
        win_hi = RESET_WINDOW_HIGH;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty pop, short buffers, phases, stitching, window extremes
        add_pops(1);
        add_buffer(1, 0, 100);
        add_buffer(25, 3, 100);
        add_pops(4);
        set_config(1'b1, 16'h0000, 16'hFFFF);
        add_buffer(9, 0, 100);
        add_buffer(20, 7, 100);
        set_config(1'b1, 16'hFFFF, 16'h0000);
        add_buffer(12, 5, 100);
        set_config(1'b1, 16'hC000, 16'hC0FF);
        add_buffer(3, 0, 100);
        add_buffer(22, 9, 100);
        add_pops(3);

        // random phases under varied settings
        for (int blk = 0; blk < 6; blk++) begin
            case (blk % 4)
                0: set_config(1'($urandom), 16'h0000, 16'hFFFF);
                1: set_config(1'b1, 16'hC000, 16'hC0FF);
                2: set_config(1'($urandom), 16'($urandom), 16'($urandom));
                default: set_config(1'b0, 16'hFFFF, 16'hFFFF);
            endcase
            for (int b = 0; b < 2; b++) begin
                if ($urandom_range(4) == 0)
                    add_buffer($urandom_range(1, 12), $urandom_range(9), 80);
                else
                    add_buffer($urandom_range(10, 30), $urandom_range(9), 85);
                add_pops($urandom_range(0, 8));
            end
            if (blk == 5) begin
                hold_send = 1'b1;
                while (s_tvalid || expected_q.size() != 0) @(posedge aclk);
                hold_send = 1'b0;
            end
        end

        // buffer longer than the scoring span, then drain part of the ring
        set_config(1'b1, RESET_WINDOW_LOW, RESET_WINDOW_HIGH);
        add_buffer(SCORE_SPAN + 20, 4, 90);
        add_pops(12);

        wait_drained();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
